// ===== hw/rtl/pdts_pkg.sv =====
package pdts_pkg;

   localparam int unsigned CNT_W  = 64;
   localparam int unsigned REG_W  = 32;
   localparam int unsigned CMD_W  = 2;

   localparam logic [REG_W-1:0] US_PER_SEC   = 32'd1000000;
   localparam logic [REG_W-1:0] DEFAULT_FREQ = 32'd24000000;
   localparam logic [REG_W-1:0] DEFAULT_PERIOD_US = 32'd1000;

   typedef enum logic [CMD_W-1:0] {
      CMD_START = 2'd0,
      CMD_EVENT = 2'd1,
      CMD_STOP  = 2'd2
   } cmd_type;

   localparam logic CSR_FREQ      = 1'b0;
   localparam logic CSR_PERIOD_US = 1'b1;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_MUL_P  = 9'b000000010,
      ST_DIV_P  = 9'b000000100,
      ST_DIV_Q  = 9'b000001000,
      ST_DIV_US = 9'b000010000,
      ST_MUL_QI = 9'b000100000,
      ST_MUL_RI = 9'b001000000,
      ST_DIV_FR = 9'b010000000,
      ST_FIN    = 9'b100000000
   } state_type;

endpackage

// ===== hw/rtl/periodic_deadline_tick_scheduler.sv =====
// Periodic tick scheduler that rearms an absolute compare deadline. Each transfer on the
// request side carries a command in tuser and the counter value in tdata, and produces
// exactly one response transfer. Multiplication and division use one shared divider that
// retires one quotient bit per cycle and one shift-add multiplier that takes one
// multiplier bit per cycle. A start runs a multiplication and a division; a stop, an
// ignored command or an event before its deadline runs none; an event at its deadline
// one division; a late event two divisions, two multiplications and a third division.
// A new request is taken only once the previous one has finished; a finished response
// may wait in the output register while the next request is accepted.
module periodic_deadline_tick_scheduler (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // now
   input  logic [1:0]   req_tuser,   // command
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // compare_value, ticks_raised, tick_count, late_us, late_max_us
   output logic [191:0] rsp_tdata,
   output logic [0:0]   rsp_tuser,   // timer_enable
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [31:0]  csr_data
);

   pdts_pkg::state_type state_ff, state_in;
   logic [31:0] freq_ff, freq_in;
   logic [31:0] per_us_ff, per_us_in;
   logic [63:0] period_ff, period_in;
   logic [63:0] nd_ff, nd_in;
   logic [31:0] total_ff, total_in;
   logic [31:0] worst_ff, worst_in;
   logic        running_ff, running_in;
   logic [63:0] now_ff, now_in;
   logic [63:0] late_ff, late_in;
   logic [31:0] raised_ff, raised_in;
   logic [31:0] late_us_ff, late_us_in;
   logic [31:0] rkeep_ff, rkeep_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] o_cmp_ff, o_cmp_in;
   logic        o_en_ff, o_en_in;
   logic [31:0] o_raised_ff, o_raised_in;
   logic [31:0] o_total_ff, o_total_in;
   logic [31:0] o_late_ff, o_late_in;
   logic [31:0] o_worst_ff, o_worst_in;

   logic        div_start, div_done;
   logic [63:0] div_a, div_b, div_quot, div_rem;
   logic        mul_start, mul_done;
   logic [63:0] mul_a, mul_prod;
   logic [31:0] mul_b;
   logic [31:0] eff_freq;
   logic [63:0] pnew;
   logic [31:0] lu;
   logic        req_fire;

   pdts_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   pdts_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_a),
      .mplier  (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   assign eff_freq   = (freq_ff == 32'd0) ? pdts_pkg::DEFAULT_FREQ : freq_ff;
   assign req_tready = (state_ff == pdts_pkg::ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      state_in    = state_ff;
      freq_in     = freq_ff;
      per_us_in   = per_us_ff;
      period_in   = period_ff;
      nd_in       = nd_ff;
      total_in    = total_ff;
      worst_in    = worst_ff;
      running_in  = running_ff;
      now_in      = now_ff;
      late_in     = late_ff;
      raised_in   = raised_ff;
      late_us_in  = late_us_ff;
      rkeep_in    = rkeep_ff;
      o_cmp_in    = o_cmp_ff;
      o_en_in     = o_en_ff;
      o_raised_in = o_raised_ff;
      o_total_in  = o_total_ff;
      o_late_in   = o_late_ff;
      o_worst_in  = o_worst_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      div_start   = 1'b0;
      div_a       = late_ff;
      div_b       = {32'd0, eff_freq};
      mul_start   = 1'b0;
      mul_a       = {32'd0, eff_freq};
      mul_b       = pdts_pkg::US_PER_SEC;
      pnew        = (div_quot == 64'd0) ? 64'd1 : div_quot;
      lu          = late_us_ff + div_quot[31:0];

      if (csr_valid) begin
         if (csr_index == pdts_pkg::CSR_FREQ) begin
            freq_in = csr_data;
         end else begin
            per_us_in = csr_data;
         end
      end

      case (state_ff)
         pdts_pkg::ST_IDLE: begin
            if (req_fire) begin
               now_in     = req_tdata;
               raised_in  = '0;
               late_us_in = '0;
               late_in    = req_tdata - nd_ff;
               state_in   = pdts_pkg::ST_FIN;
               case (req_tuser)
                  pdts_pkg::CMD_START: begin
                     mul_start = 1'b1;
                     mul_a     = {32'd0, eff_freq};
                     mul_b     = per_us_ff;
                     state_in  = pdts_pkg::ST_MUL_P;
                  end
                  pdts_pkg::CMD_EVENT: begin
                     if (running_ff) begin
                        if (req_tdata >= nd_ff) begin
                           div_start = 1'b1;
                           div_a     = req_tdata - nd_ff;
                           div_b     = period_ff;
                           state_in  = pdts_pkg::ST_DIV_Q;
                        end else begin
                           nd_in     = nd_ff + period_ff;
                           total_in  = total_ff + 32'd1;
                           raised_in = 32'd1;
                        end
                     end
                  end
                  pdts_pkg::CMD_STOP: begin
                     running_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         pdts_pkg::ST_MUL_P: begin
            if (mul_done) begin
               div_start = 1'b1;
               div_a     = mul_prod;
               div_b     = {32'd0, pdts_pkg::US_PER_SEC};
               state_in  = pdts_pkg::ST_DIV_P;
            end
         end
         pdts_pkg::ST_DIV_P: begin
            if (div_done) begin
               period_in  = pnew;
               nd_in      = now_ff + pnew;
               total_in   = '0;
               worst_in   = '0;
               running_in = 1'b1;
               state_in   = pdts_pkg::ST_FIN;
            end
         end
         pdts_pkg::ST_DIV_Q: begin
            if (div_done) begin
               nd_in     = now_ff - div_rem + period_ff;
               raised_in = (div_quot >= 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF
                           : div_quot[31:0] + 32'd1;
               total_in  = total_ff + div_quot[31:0] + 32'd1;
               if (late_ff != 64'd0) begin
                  div_start = 1'b1;
                  div_a     = late_ff;
                  div_b     = {32'd0, eff_freq};
                  state_in  = pdts_pkg::ST_DIV_US;
               end else begin
                  state_in = pdts_pkg::ST_FIN;
               end
            end
         end
         pdts_pkg::ST_DIV_US: begin
            if (div_done) begin
               rkeep_in  = div_rem[31:0];
               mul_start = 1'b1;
               mul_a     = div_quot;
               mul_b     = pdts_pkg::US_PER_SEC;
               state_in  = pdts_pkg::ST_MUL_QI;
            end
         end
         pdts_pkg::ST_MUL_QI: begin
            if (mul_done) begin
               late_us_in = mul_prod[31:0];
               mul_start  = 1'b1;
               mul_a      = {32'd0, rkeep_ff};
               mul_b      = pdts_pkg::US_PER_SEC;
               state_in   = pdts_pkg::ST_MUL_RI;
            end
         end
         pdts_pkg::ST_MUL_RI: begin
            if (mul_done) begin
               div_start = 1'b1;
               div_a     = mul_prod;
               div_b     = {32'd0, eff_freq};
               state_in  = pdts_pkg::ST_DIV_FR;
            end
         end
         pdts_pkg::ST_DIV_FR: begin
            if (div_done) begin
               late_us_in = lu;
               if (lu > worst_ff) begin
                  worst_in = lu;
               end
               state_in = pdts_pkg::ST_FIN;
            end
         end
         pdts_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               o_cmp_in     = nd_ff;
               o_en_in      = running_ff;
               o_raised_in  = raised_ff;
               o_total_in   = total_ff;
               o_late_in    = late_us_ff;
               o_worst_in   = worst_ff;
               rsp_valid_in = 1'b1;
               state_in     = pdts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pdts_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      late_ff     <= late_in;
      raised_ff   <= raised_in;
      late_us_ff  <= late_us_in;
      rkeep_ff    <= rkeep_in;
      o_cmp_ff    <= o_cmp_in;
      o_en_ff     <= o_en_in;
      o_raised_ff <= o_raised_in;
      o_total_ff  <= o_total_in;
      o_late_ff   <= o_late_in;
      o_worst_ff  <= o_worst_in;
      if (reset) begin
         state_ff     <= pdts_pkg::ST_IDLE;
         freq_ff      <= pdts_pkg::DEFAULT_FREQ;
         per_us_ff    <= pdts_pkg::DEFAULT_PERIOD_US;
         period_ff    <= 64'd1;
         nd_ff        <= '0;
         total_ff     <= '0;
         worst_ff     <= '0;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         freq_ff      <= freq_in;
         per_us_ff    <= per_us_in;
         period_ff    <= period_in;
         nd_ff        <= nd_in;
         total_ff     <= total_in;
         worst_ff     <= worst_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {o_worst_ff, o_late_ff, o_total_ff, o_raised_ff, o_cmp_ff};
   assign rsp_tuser  = o_en_ff;

endmodule

// ===== hw/rtl/pdts_div.sv =====
module pdts_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient,
   output logic [63:0] remainder
);

   logic [63:0] quo_ff, quo_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic [65:0] diff;
   logic        ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[63]};
      diff    = {1'b0, trial} - {2'b00, dvs_ff};
      ge      = ~diff[65];
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = 6'd63;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[62:0], ge};
         rem_in = ge ? diff[63:0] : trial[63:0];
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== hw/rtl/pdts_mul.sv =====
module pdts_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] mcand,
   input  logic [31:0] mplier,
   output logic        done,
   output logic [63:0] product
);

   logic [63:0] acc_ff, acc_in;
   logic [63:0] a_ff, a_in;
   logic [31:0] b_ff, b_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         a_in    = mcand;
         b_in    = mplier;
         cnt_in  = 5'd31;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in   = {a_ff[62:0], 1'b0};
         b_in   = {1'b0, b_ff[31:1]};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== hw/rtl/pdts_checker.sv =====
module pdts_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [191:0] rsp_tdata,
   input logic [0:0]   rsp_tuser
);

   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("Response valid directly after reset.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled response changed.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[95:64] == 32'd0)
      else $error("Ticks raised while the timer is stopped.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[191:160] >= rsp_tdata[159:128])
      else $error("Worst lateness below the lateness of this transfer.");

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("Request accepted while the previous one is in work.");

endmodule

bind periodic_deadline_tick_scheduler pdts_checker u_pdts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== verif/tb.sv =====
module tb;

   localparam logic [1:0] CMD_RSVD = 2'd3;

   typedef struct packed {
      logic [31:0] late_max_us;
      logic [31:0] late_us;
      logic [31:0] tick_count;
      logic [31:0] ticks_raised;
      logic [63:0] compare_value;
   } rsp_fields_type;

   class tick_scoreboard;
      logic [63:0] freq, tick_period;
      logic [63:0] period_ticks, next_deadline;
      logic [31:0] total_ticks, worst_late;
      bit running;
      rsp_fields_type pending_data[$];
      bit pending_enable[$];
      int errors;

      function void init();
         freq = {32'd0, pdts_pkg::DEFAULT_FREQ};
         tick_period = {32'd0, pdts_pkg::DEFAULT_PERIOD_US};
         period_ticks = 64'd1;
         next_deadline = '0;
         total_ticks = '0;
         worst_late = '0;
         running = 1'b0;
         errors = 0;
      endfunction

      function void write_reg(logic idx, logic [31:0] val);
         if (idx == pdts_pkg::CSR_FREQ) freq = {32'd0, val};
         else tick_period = {32'd0, val};
      endfunction

      function void note_request(logic [1:0] cmd, logic [63:0] now);
         logic [63:0] f, p, late, q, k, us;
         logic [127:0] prod;
         rsp_fields_type r;
         f = (freq == 64'd0) ? {32'd0, pdts_pkg::DEFAULT_FREQ} : freq;
         r.ticks_raised = '0;
         r.late_us = '0;
         if (cmd == pdts_pkg::CMD_START) begin
            prod = f * tick_period;
            p = prod[63:0] / 64'd1000000;
            period_ticks = (p == 64'd0) ? 64'd1 : p;
            total_ticks = '0;
            worst_late = '0;
            next_deadline = now + period_ticks;
            running = 1'b1;
         end else if (cmd == pdts_pkg::CMD_EVENT) begin
            if (running) begin
               q = '0;
               if (now > next_deadline) begin
                  late = now - next_deadline;
                  us = (late / f) * 64'd1000000 + ((late % f) * 64'd1000000) / f;
                  r.late_us = us[31:0];
                  if (r.late_us > worst_late) worst_late = r.late_us;
               end
               if (now >= next_deadline) q = (now - next_deadline) / period_ticks;
               k = q + 64'd1;
               r.ticks_raised = (q >= 64'hFFFFFFFF) ? 32'hFFFFFFFF : k[31:0];
               next_deadline = next_deadline + k * period_ticks;
               total_ticks = total_ticks + k[31:0];
            end
         end else if (cmd == pdts_pkg::CMD_STOP) begin
            running = 1'b0;
         end
         r.compare_value = next_deadline;
         r.tick_count = total_ticks;
         r.late_max_us = worst_late;
         pending_data.push_back(r);
         pending_enable.push_back(running);
      endfunction

      function void check_response(logic [191:0] data, logic en);
         rsp_fields_type e, a;
         bit ee;
         if (pending_data.size() == 0) begin
            $error("unexpected response transfer");
            errors++;
            return;
         end
         e = pending_data.pop_front();
         ee = pending_enable.pop_front();
         a = data;
         if (a.compare_value !== e.compare_value) begin
            $error("compare_value exp %h got %h", e.compare_value, a.compare_value);
            errors++;
         end
         if (en !== ee) begin
            $error("timer_enable exp %0d got %0d", ee, en);
            errors++;
         end
         if (a.ticks_raised !== e.ticks_raised) begin
            $error("ticks_raised exp %h got %h", e.ticks_raised, a.ticks_raised);
            errors++;
         end
         if (a.tick_count !== e.tick_count) begin
            $error("tick_count exp %h got %h", e.tick_count, a.tick_count);
            errors++;
         end
         if (a.late_us !== e.late_us) begin
            $error("late_us exp %h got %h", e.late_us, a.late_us);
            errors++;
         end
         if (a.late_max_us !== e.late_max_us) begin
            $error("late_max_us exp %h got %h", e.late_max_us, a.late_max_us);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [63:0] req_tdata = 0;
   logic [1:0] req_tuser = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [191:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic csr_valid = 0;
   logic csr_ready;
   logic csr_index = 0;
   logic [31:0] csr_data = 0;

   tick_scoreboard sb;
   bit sink_idle_ok;

   periodic_deadline_tick_scheduler dut (.*);

   always #2 clock = ~clock;

   function int pick_gap();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 300);
      return $urandom_range(0, 4);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser[0]);
      end
   end

   initial begin
      int g;
      @(posedge clock);
      while (1) begin
         @(posedge clock);
         if (sink_idle_ok && $urandom_range(0, 3) == 0) begin
            g = pick_gap();
            if (g > 0) begin
               rsp_tready <= 0;
               repeat (g) @(posedge clock);
            end
         end
         rsp_tready <= 1;
      end
   end

   task automatic send_request(logic [1:0] cmd, logic [63:0] now);
      int g;
      g = pick_gap();
      repeat (g + 1) @(posedge clock);
      req_tvalid <= 1;
      req_tuser <= cmd;
      req_tdata <= now;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(cmd, now);
      req_tvalid <= 0;
   endtask

   task automatic write_csr(logic idx, logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, val);
      csr_valid <= 0;
   endtask

   task automatic drain();
      while (sb.pending_data.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic run_event_burst(int n);
      logic [63:0] base, p;
      for (int i = 0; i < n; i++) begin
         base = sb.next_deadline;
         p = sb.period_ticks;
         case ($urandom_range(0, 9))
            0: send_request(pdts_pkg::CMD_EVENT, rand64());
            1: send_request(pdts_pkg::CMD_EVENT, base - $urandom_range(0, 1000));
            2: send_request(pdts_pkg::CMD_EVENT, base + p * $urandom_range(0, 50)
                                         + $urandom_range(0, 3));
            3: send_request(pdts_pkg::CMD_STOP, rand64());
            4: send_request(pdts_pkg::CMD_START, rand64());
            5: send_request(CMD_RSVD, rand64());
            default: send_request(pdts_pkg::CMD_EVENT, base + $urandom_range(0, 3000));
         endcase
      end
   endtask

   initial begin
      int phase;
      sb = new();
      sb.init();
      sink_idle_ok = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      sink_idle_ok = 1;

      send_request(pdts_pkg::CMD_EVENT, 64'd5);
      send_request(pdts_pkg::CMD_START, 64'd0);
      send_request(pdts_pkg::CMD_EVENT, 64'd0);
      send_request(pdts_pkg::CMD_EVENT, sb.next_deadline);
      send_request(pdts_pkg::CMD_EVENT, sb.next_deadline + 1);
      send_request(pdts_pkg::CMD_EVENT, sb.next_deadline + 64'd24000000 * 3 + 7);
      send_request(pdts_pkg::CMD_EVENT, 64'hFFFFFFFFFFFFFFFF);
      send_request(CMD_RSVD, 64'h1234);
      send_request(pdts_pkg::CMD_STOP, 64'hFFFFFFFFFFFFFFFF);
      send_request(pdts_pkg::CMD_EVENT, 64'h10);
      send_request(pdts_pkg::CMD_START, 64'hFFFFFFFFFFFFFFF0);
      send_request(pdts_pkg::CMD_EVENT, 64'hFFFFFFFFFFFFFFFF);
      drain();

      write_csr(pdts_pkg::CSR_FREQ, 32'd1);
      write_csr(pdts_pkg::CSR_PERIOD_US, 32'd0);
      send_request(pdts_pkg::CMD_START, 64'd100);
      send_request(pdts_pkg::CMD_EVENT, 64'hFFFFFFFFFFFFFFFF);
      send_request(pdts_pkg::CMD_EVENT, 64'd0);
      drain();
      write_csr(pdts_pkg::CSR_FREQ, 32'hFFFFFFFF);
      write_csr(pdts_pkg::CSR_PERIOD_US, 32'hFFFFFFFF);
      send_request(pdts_pkg::CMD_START, 64'd0);
      send_request(pdts_pkg::CMD_EVENT, 64'hFFFFFFFFFFFFFFFF);
      send_request(pdts_pkg::CMD_EVENT, 64'h8000000000000000);
      drain();
      write_csr(pdts_pkg::CSR_FREQ, 32'd0);
      write_csr(pdts_pkg::CSR_PERIOD_US, 32'd1);
      send_request(pdts_pkg::CMD_START, 64'h5555555555555555);
      send_request(pdts_pkg::CMD_EVENT, 64'hAAAAAAAAAAAAAAAA);
      drain();

      for (phase = 0; phase < 10; phase++) begin
         case (phase % 4)
            0: write_csr(pdts_pkg::CSR_FREQ, $urandom());
            1: write_csr(pdts_pkg::CSR_FREQ, $urandom_range(1, 100000000));
            2: write_csr(pdts_pkg::CSR_FREQ,
                         $urandom_range(0, 1) ? 32'd0 : 32'd24000000);
            default: write_csr(pdts_pkg::CSR_FREQ, $urandom_range(1, 1000));
         endcase
         write_csr(pdts_pkg::CSR_PERIOD_US,
                   (phase % 3 == 0) ? $urandom() : $urandom_range(0, 5000));
         send_request(pdts_pkg::CMD_START, rand64());
         run_event_burst(99);
         if (phase == 4) begin
            while (sb.pending_data.size() != 0) @(posedge clock);
            run_event_burst(5);
         end
         drain();
      end

      if (sb.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #20000000;
      $display("Test completed with failures");
      $finish;
   end
endmodule

// ===== periodic_deadline_tick_scheduler.f =====
hw/rtl/pdts_pkg.sv
hw/rtl/pdts_div.sv
hw/rtl/pdts_mul.sv
hw/rtl/periodic_deadline_tick_scheduler.sv
hw/rtl/pdts_checker.sv
verif/tb.sv
